>>> hdl/exp_taylor_series_double_macros.svh
// Assertion macros for the exp Taylor series block.
`ifndef EXP_TAYLOR_SERIES_DOUBLE_MACROS_SVH
`define EXP_TAYLOR_SERIES_DOUBLE_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every rising clock edge outside reset
`define ETSD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// when trig holds, resp must hold in the next cycle
`define ETSD_ASSERT_NEXT(lbl, trig, resp, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (resp)) else $error(msg);
`else
`define ETSD_ASSERT_ALWAYS(lbl, cond, msg)
`define ETSD_ASSERT_NEXT(lbl, trig, resp, msg)
`endif
`endif

>>> hdl/etsd_pkg.sv
// Constants for the exp Taylor series block.
package etsd_pkg;
  localparam logic [63:0] ONE_BITS      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] POS_INF_BITS  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT     = 64'h0008_0000_0000_0000;
  localparam logic [62:0] LIMIT_MAG     = 63'h4086_2800_0000_0000;  // |709.0|
  localparam logic [62:0] EPS_MAG       = 63'h3CD2_03AF_9EE7_5616;  // |1e-15|
  localparam logic [6:0]  MAX_TERMS_RST = 7'd100;
  localparam int          DIV_BITS      = 120;  // mantissa << 67
  localparam int          DIV_RADIX     = 8;    // quotient bits per cycle
  localparam int          DIV_CYCLES    = DIV_BITS / DIV_RADIX;
  localparam int          MUL_PARTS     = 4;    // 27x27 partial products per multiply
  localparam logic [11:0] EXP_BIAS      = 12'd1023;
endpackage

>>> hdl/exp_taylor_series_double.sv
// Top level: IEEE double exp(x) by a Taylor series on one shared sequenced datapath.
//
// One item in, one item out. Zero gives 1.0, x above 709 gives +inf (overflowed),
// x below -709 gives +0 (underflowed), NaN comes back quieted; those skip the
// series. Otherwise the series 1 + x + x^2/2! + ... runs in round-to-nearest
// double arithmetic until |term| <= 1e-15 or the index reaches cfg max_terms.
// Step one sets term = x, then does the add. Every later step runs x/n (long
// division by the small integer n, 8 quotient bits a cycle), rounds the quotient,
// forms term*q (four 27x27 partial products on one multiplier, then round) and
// does the add (align, add, leading-zero count, normalize/round). The result is
// then handed off in S_FIN, which waits while the output register is still full.
// in_ready is high only while idle; a finished item waits in the output register,
// and the next item can be taken meanwhile. max_terms is written through the cfg
// channel, which is always ready.
`include "exp_taylor_series_double_macros.svh"
module exp_taylor_series_double
  import etsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_bits,
  output logic        out_overflowed,
  output logic        out_underflowed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_max_terms
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DRND, S_MUL, S_MRND,
    S_ALGN, S_ADD, S_LZC, S_NORM, S_FIN
  } state_t;

  // round to nearest even and pack; e is the biased exponent field
  function automatic logic [63:0] pack_round(input logic s, input logic [11:0] e,
                                             input logic [52:0] m, input logic g,
                                             input logic st);
    logic [53:0] r;
    logic [11:0] ef;
    r  = {1'b0, m} + 54'(g & (st | m[0]));
    ef = e;
    if (r[53]) begin
      ef = e + 12'd1;
      r  = r >> 1;
    end else if (e == 12'd0 && r[52]) begin
      ef = 12'd1;
    end
    return {s, ef[10:0], r[51:0]};
  endfunction

  state_t state_r, state_nxt;
  logic [6:0]  max_terms_r, max_terms_nxt;
  logic [6:0]  n_r, n_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] result_r, result_nxt;
  logic [63:0] term_r, term_nxt;
  logic [63:0] res_r, res_nxt;
  logic        ovf_r, ovf_nxt, unf_r, unf_nxt;
  // divider
  logic [DIV_BITS-1:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  // quotient x/n
  logic        q_sgn_r, q_sgn_nxt;
  logic [10:0] q_exp_r, q_exp_nxt;
  logic [52:0] q_man_r, q_man_nxt;
  // multiplier
  logic [105:0] prod_r, prod_nxt;
  // adder
  logic        a_sgn_r, a_sgn_nxt, a_sub_r, a_sub_nxt;
  logic [10:0] a_exp_r, a_exp_nxt;
  logic [55:0] a_ma_r, a_ma_nxt, a_mb_r, a_mb_nxt;
  logic [56:0] a_sum_r, a_sum_nxt;
  logic [5:0]  a_sh_r, a_sh_nxt;
  logic        a_r1_r, a_r1_nxt;
  // outputs
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_res_r, out_res_nxt;
  logic        out_ovf_r, out_ovf_nxt, out_unf_r, out_unf_nxt;

  // combinational helpers
  logic [7:0]  dv_t;
  logic [6:0]  dv_rem;
  logic [DIV_BITS-1:0] dv_quo, dv_dvd, dq_mask;
  logic [6:0]  dq_p;
  logic [63:0] dq_pack, mr_pack, ad_pack;
  logic [26:0] mul_a, mul_b;
  logic [53:0] mul_p;
  logic [105:0] pp_add;
  logic [11:0] mr_exp;
  logic        mr_top;
  logic [63:0] big, sml;
  logic [10:0] eb_big, eb_sml, al_d;
  logic [55:0] mb_ext, mb_shift;
  logic [5:0]  al_sh;
  logic [5:0]  lz;
  logic [10:0] lz_lim;
  logic [55:0] nm;
  logic [11:0] nm_exp;
  logic        more;

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_result_bits = out_res_r;
  assign out_overflowed  = out_ovf_r;
  assign out_underflowed = out_unf_r;

  always_comb begin
    // divider: eight restoring steps per cycle on the narrow remainder
    dv_rem = rem_r;
    dv_quo = quo_r;
    dv_dvd = dvd_r;
    for (int k = 0; k < DIV_RADIX; k++) begin
      dv_t   = {dv_rem, dv_dvd[DIV_BITS-1]};
      dv_dvd = dv_dvd << 1;
      if (dv_t >= {1'b0, n_r}) begin
        dv_rem = 7'(dv_t - {1'b0, n_r});
        dv_quo = {dv_quo[DIV_BITS-2:0], 1'b1};
      end else begin
        dv_rem = dv_t[6:0];
        dv_quo = {dv_quo[DIV_BITS-2:0], 1'b0};
      end
    end

    // quotient leading one sits in bits 112..118
    dq_p = 7'd112;
    for (int k = 0; k < 7; k++) begin
      if (quo_r[112+k]) dq_p = 7'(112 + k);
    end
    dq_mask = ~({DIV_BITS{1'b1}} << (dq_p - 7'd53));
    dq_pack = pack_round(x_r[63],
                         {1'b0, x_r[62:52]} - (12'd119 - {5'd0, dq_p}),
                         quo_r[dq_p -: 53], quo_r[dq_p - 7'd53],
                         (|(quo_r & dq_mask)) | (rem_r != 7'd0));

    // multiplier: one 27x27 partial product per cycle, cnt_r picks the halves
    mul_a = cnt_r[1] ? {2'b01, term_r[51:27]} : term_r[26:0];
    mul_b = cnt_r[0] ? {1'b0, q_man_r[52:27]} : q_man_r[26:0];
    mul_p = mul_a * mul_b;
    case (cnt_r[1:0])
      2'd0:    pp_add = {52'd0, mul_p};
      2'd3:    pp_add = {mul_p[51:0], 54'd0};
      default: pp_add = {25'd0, mul_p, 27'd0};
    endcase
    mr_top = prod_r[105];
    mr_exp = {1'b0, term_r[62:52]} + {1'b0, q_exp_r} - EXP_BIAS + {11'd0, mr_top};
    if (mr_top) begin
      mr_pack = pack_round(term_r[63] ^ q_sgn_r, mr_exp, prod_r[105:53], prod_r[52],
                           |prod_r[51:0]);
    end else begin
      mr_pack = pack_round(term_r[63] ^ q_sgn_r, mr_exp, prod_r[104:52], prod_r[51],
                           |prod_r[50:0]);
    end

    // adder alignment: larger magnitude first
    if (result_r[62:0] >= term_r[62:0]) begin
      big = result_r;
      sml = term_r;
    end else begin
      big = term_r;
      sml = result_r;
    end
    eb_big = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    eb_sml = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    al_d   = eb_big - eb_sml;
    al_sh  = (al_d > 11'd56) ? 6'd56 : al_d[5:0];
    mb_ext = {(sml[62:52] != 11'd0), sml[51:0], 3'b000};
    mb_shift = mb_ext >> al_sh;
    mb_shift[0] = mb_shift[0] | (|(mb_ext & ~({56{1'b1}} << al_sh)));

    // leading zeros of the sum, clamped so the exponent stays at least one
    lz = 6'd56;
    for (int k = 0; k < 56; k++) begin
      if (a_sum_r[k]) lz = 6'(55 - k);
    end
    lz_lim = a_exp_r - 11'd1;
    if ({5'd0, lz} > lz_lim) a_sh_nxt = lz_lim[5:0];
    else a_sh_nxt = lz;

    // normalize and round the sum
    if (a_r1_r) begin
      nm     = {a_sum_r[56:2], a_sum_r[1] | a_sum_r[0]};
      nm_exp = {1'b0, a_exp_r} + 12'd1;
    end else begin
      nm     = a_sum_r[55:0] << a_sh_r;
      nm_exp = nm[55] ? ({1'b0, a_exp_r} - {6'd0, a_sh_r}) : 12'd0;
    end
    if (a_sum_r == 57'd0) ad_pack = 64'd0;
    else ad_pack = pack_round(a_sgn_r, nm_exp, nm[55:3], nm[2], |nm[1:0]);
    more = (term_r[62:0] > EPS_MAG) && ((n_r + 7'd1) < max_terms_r);
  end

  always_comb begin
    state_nxt     = state_r;
    max_terms_nxt = max_terms_r;
    n_nxt = n_r;  x_nxt = x_r;  result_nxt = result_r;  term_nxt = term_r;
    res_nxt = res_r;  ovf_nxt = ovf_r;  unf_nxt = unf_r;
    dvd_nxt = dvd_r;  quo_nxt = quo_r;  rem_nxt = rem_r;  cnt_nxt = cnt_r;
    q_sgn_nxt = q_sgn_r;  q_exp_nxt = q_exp_r;  q_man_nxt = q_man_r;
    prod_nxt = prod_r;
    a_sgn_nxt = a_sgn_r;  a_sub_nxt = a_sub_r;  a_exp_nxt = a_exp_r;
    a_ma_nxt = a_ma_r;  a_mb_nxt = a_mb_r;  a_sum_nxt = a_sum_r;  a_r1_nxt = a_r1_r;
    out_valid_nxt = out_valid_r;  out_res_nxt = out_res_r;
    out_ovf_nxt = out_ovf_r;  out_unf_nxt = out_unf_r;

    if (cfg_valid) max_terms_nxt = cfg_max_terms;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_x_bits;
          ovf_nxt = 1'b0;
          unf_nxt = 1'b0;
          state_nxt = S_FIN;
          if (in_x_bits[62:52] == 11'h7FF && in_x_bits[51:0] != 52'd0) begin
            res_nxt = in_x_bits | QUIET_BIT;
          end else if (in_x_bits[62:0] == 63'd0) begin
            res_nxt = ONE_BITS;
          end else if (in_x_bits[62:0] > LIMIT_MAG) begin
            res_nxt = in_x_bits[63] ? 64'd0 : POS_INF_BITS;
            ovf_nxt = !in_x_bits[63];
            unf_nxt = in_x_bits[63];
          end else begin
            // first step: term = x exactly, then 1 + x
            result_nxt = ONE_BITS;
            term_nxt   = in_x_bits;
            n_nxt      = 7'd1;
            state_nxt  = S_ALGN;
          end
        end
      end
      S_DIV: begin
        dvd_nxt = dv_dvd;
        quo_nxt = dv_quo;
        rem_nxt = dv_rem;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(DIV_CYCLES - 1)) state_nxt = S_DRND;
      end
      S_DRND: begin
        q_sgn_nxt = dq_pack[63];
        q_exp_nxt = dq_pack[62:52];
        q_man_nxt = {1'b1, dq_pack[51:0]};
        prod_nxt  = '0;
        cnt_nxt   = 4'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = prod_r + pp_add;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'(MUL_PARTS - 1)) state_nxt = S_MRND;
      end
      S_MRND: begin
        term_nxt  = mr_pack;
        state_nxt = S_ALGN;
      end
      S_ALGN: begin
        a_sgn_nxt = big[63];
        a_sub_nxt = big[63] ^ sml[63];
        a_exp_nxt = eb_big;
        a_ma_nxt  = {(big[62:52] != 11'd0), big[51:0], 3'b000};
        a_mb_nxt  = mb_shift;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        a_sum_nxt = a_sub_r ? ({1'b0, a_ma_r} - {1'b0, a_mb_r})
                            : ({1'b0, a_ma_r} + {1'b0, a_mb_r});
        state_nxt = S_LZC;
      end
      S_LZC: begin
        a_r1_nxt  = a_sum_r[56];
        state_nxt = S_NORM;
      end
      S_NORM: begin
        result_nxt = ad_pack;
        n_nxt      = n_r + 7'd1;
        if (more) begin
          dvd_nxt   = {1'b1, x_r[51:0], 67'd0};
          quo_nxt   = '0;
          rem_nxt   = 7'd0;
          cnt_nxt   = 4'd0;
          state_nxt = S_DIV;
        end else begin
          res_nxt   = ad_pack;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_ovf_nxt   = ovf_r;
          out_unf_nxt   = unf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_terms_r <= MAX_TERMS_RST;
      out_valid_r <= 1'b0;
      n_r         <= 7'd1;
      cnt_r       <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      max_terms_r <= max_terms_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
    end
    x_r <= x_nxt;  result_r <= result_nxt;  term_r <= term_nxt;
    res_r <= res_nxt;  ovf_r <= ovf_nxt;  unf_r <= unf_nxt;
    dvd_r <= dvd_nxt;  quo_r <= quo_nxt;  rem_r <= rem_nxt;
    q_sgn_r <= q_sgn_nxt;  q_exp_r <= q_exp_nxt;  q_man_r <= q_man_nxt;
    prod_r <= prod_nxt;
    a_sgn_r <= a_sgn_nxt;  a_sub_r <= a_sub_nxt;  a_exp_r <= a_exp_nxt;
    a_ma_r <= a_ma_nxt;  a_mb_r <= a_mb_nxt;  a_sum_r <= a_sum_nxt;
    a_sh_r <= a_sh_nxt;  a_r1_r <= a_r1_nxt;
    out_res_r <= out_res_nxt;  out_ovf_r <= out_ovf_nxt;  out_unf_r <= out_unf_nxt;
  end

  `ETSD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `ETSD_ASSERT_ALWAYS(a_index_nonzero, state_r == S_IDLE || n_r != 7'd0, "term index wrapped")
  `ETSD_ASSERT_ALWAYS(a_div_count, state_r != S_DIV || cnt_r < 4'(DIV_CYCLES), "divider overrun")
  `ETSD_ASSERT_ALWAYS(a_flags_excl, !(out_valid && out_overflowed && out_underflowed), "both flags")

endmodule

>>> tb/exp_taylor_series_double_tb.sv
// Self-checking testbench for the exp(x) Taylor series block, double precision.
module exp_taylor_series_double_tb
  import etsd_pkg::*;
();

  localparam int MAX_ERR_SHOWN = 10;
  localparam int STALL_LIMIT   = 40000;  // must lie above the worst item plus output stall
  localparam int RAND_PER_PHASE = 95;

  // one expected output item
  typedef struct packed {
    logic [63:0] bits;
    logic        ovf;
    logic        unf;
  } exp_res_t;

  // directed row: argument, plus a hand-typed answer where it is obvious
  typedef struct packed {
    logic [63:0] x;
    logic        pinned;
    exp_res_t    res;
  } exp_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_x_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_bits;
  logic        out_overflowed;
  logic        out_underflowed;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_max_terms = '0;

  exp_res_t pending_exp_q[$];   // expected results in arrival order
  exp_res_t pinned_q[$];        // hand-typed answers for directed rows
  logic     pinned_use_q[$];
  logic [6:0] terms_limit = MAX_TERMS_RST;   // mirror of max_terms

  int send_idle_pct = 18;
  int recv_idle_pct = 68;
  int mismatches = 0;
  int results_seen = 0;
  int series_items = 0;
  int stall_cycles = 0;

  exp_taylor_series_double u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_bits      (in_x_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_bits(out_result_bits),
    .out_overflowed (out_overflowed),
    .out_underflowed(out_underflowed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_terms  (cfg_max_terms)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor: exp(x) as the truncated series, in double arithmetic.
  function automatic exp_res_t exp_series(input logic [63:0] xb, input logic [6:0] lim);
    exp_res_t r;
    real x, sum, term;
    int n;
    bit more;
    r = '0;
    x = $bitstoreal(xb);
    if (xb[62:52] == '1 && xb[51:0] != '0) begin
      r.bits = xb | QUIET_BIT;           // NaN comes back quieted
    end else if (x == 0.0) begin
      r.bits = ONE_BITS;                 // covers -0 as well
    end else if (x > 709.0) begin
      r.bits = POS_INF_BITS;
      r.ovf = 1'b1;
    end else if (x < -709.0) begin
      r.bits = '0;
      r.unf = 1'b1;
    end else begin
      sum = 1.0;
      term = 1.0;
      n = 1;
      do begin
        term = term * (x / real'(n));
        sum = sum + term;
        n++;
        more = (term > 1e-15 || term < -1e-15) && (n < int'(lim));
      end while (more);
      r.bits = $realtobits(sum);
    end
    return r;
  endfunction

  // Random argument: mostly in-range values that run the series for real,
  // plus raw bit patterns, values around the cutoffs, infinities, NaNs, denormals and zeros.
  function automatic logic [63:0] rand_arg();
    int pick;
    real span, v;
    logic [63:0] b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return {$urandom, $urandom};
    end else if (pick < 85) begin
      span = (pick < 60) ? 4.0 : (pick < 75) ? 40.0 : 709.0;
      v = ($urandom / 4294967296.0) * 2.0 * span - span;
      b = $realtobits(v);
      b[19:0] = 20'($urandom);
      return b;
    end else begin
      case ($urandom_range(5))
        0: return {1'($urandom_range(1)), 63'h4086_2800_0000_0000} +
                  64'($urandom_range(2)) - 64'd1;
        1: return {1'($urandom_range(1)), 11'h7FF, 52'h0};
        2: return {1'($urandom_range(1)), 11'h7FF, 20'($urandom) | 20'h1, 32'($urandom)};
        3: return {1'($urandom_range(1)), 11'h0, 20'($urandom), 32'($urandom)};
        4: return {1'($urandom_range(1)), 63'h0};
        default: return {1'($urandom_range(1)), 11'($urandom_range(900, 1050)),
                         20'($urandom), 32'($urandom)};
      endcase
    end
  endfunction

  // Monitor: prediction on input accept, check on output accept, watchdog.
  always @(posedge clk) begin
    exp_res_t want;
    logic use_pin;
    exp_res_t pin;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) terms_limit = cfg_max_terms;
      if (in_valid && in_ready) begin
        want = exp_series(in_x_bits, terms_limit);
        if (pinned_use_q.size() > 0) begin
          use_pin = pinned_use_q.pop_front();
          pin = pinned_q.pop_front();
          if (use_pin) want = pin;
        end
        if (!want.ovf && !want.unf && in_x_bits[62:52] != '1 && in_x_bits[62:0] != '0)
          series_items++;
        pending_exp_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_ERR_SHOWN)
            $display("ERROR: unexpected item bits=%h ovf=%b unf=%b",
                     out_result_bits, out_overflowed, out_underflowed);
        end else begin
          want = pending_exp_q.pop_front();
          if (out_result_bits !== want.bits || out_overflowed !== want.ovf ||
              out_underflowed !== want.unf) begin
            mismatches++;
            if (mismatches <= MAX_ERR_SHOWN)
              $display("ERROR: item %0d exp %h/%b/%b got %h/%b/%b", results_seen,
                       want.bits, want.ovf, want.unf,
                       out_result_bits, out_overflowed, out_underflowed);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("exp_taylor_series_double test failed");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_arg(input logic [63:0] x);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_x_bits <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // max_terms write, only with nothing in flight
  task automatic write_terms(input logic [6:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_exp_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_terms <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  exp_row_t directed_rows[] = '{
    '{64'h0000_0000_0000_0000, 1'b1, '{ONE_BITS, 1'b0, 1'b0}},         // +0
    '{64'h8000_0000_0000_0000, 1'b1, '{ONE_BITS, 1'b0, 1'b0}},         // -0
    '{64'h7FF0_0000_0000_0000, 1'b1, '{POS_INF_BITS, 1'b1, 1'b0}},     // +inf
    '{64'hFFF0_0000_0000_0000, 1'b1, '{64'h0, 1'b0, 1'b1}},            // -inf
    '{64'h4086_2800_0000_0001, 1'b1, '{POS_INF_BITS, 1'b1, 1'b0}},     // just above 709
    '{64'hC086_2800_0000_0001, 1'b1, '{64'h0, 1'b0, 1'b1}},            // just below -709
    '{64'h7FEF_FFFF_FFFF_FFFF, 1'b1, '{POS_INF_BITS, 1'b1, 1'b0}},     // max finite
    '{64'hFFEF_FFFF_FFFF_FFFF, 1'b1, '{64'h0, 1'b0, 1'b1}},
    '{64'h7FF8_0000_0000_0000, 1'b1, '{64'h7FF8_0000_0000_0000, 1'b0, 1'b0}}, // quiet NaN
    '{64'h7FF0_0000_0000_0001, 1'b1, '{64'h7FF8_0000_0000_0001, 1'b0, 1'b0}}, // signaling
    '{64'hFFF4_0000_0000_0000, 1'b1, '{64'hFFFC_0000_0000_0000, 1'b0, 1'b0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0}},
    '{64'h4086_2800_0000_0000, 1'b0, '0},    // exactly 709: runs the series
    '{64'hC086_2800_0000_0000, 1'b0, '0},    // exactly -709
    '{64'h0000_0000_0000_0001, 1'b0, '0},    // smallest denormal
    '{64'h8000_0000_0000_0001, 1'b0, '0},
    '{64'h3C9C_D2B2_97D8_89BC, 1'b0, '0},    // 1e-16, first term already tiny
    '{64'h3FF0_0000_0000_0000, 1'b0, '0},    // 1.0
    '{64'hBFF0_0000_0000_0000, 1'b0, '0},    // -1.0
    '{64'h3FE0_0000_0000_0000, 1'b0, '0},    // 0.5
    '{64'h4059_0000_0000_0000, 1'b0, '0},    // 100.0, hits the term cap
    '{64'hC034_0000_0000_0000, 1'b0, '0}     // -20.0
  };

  initial begin
    logic [6:0] phase_terms[4];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset value of max_terms
    foreach (directed_rows[i]) begin
      pinned_use_q.push_back(directed_rows[i].pinned);
      pinned_q.push_back(directed_rows[i].res);
      send_arg(directed_rows[i].x);
    end

    // random phases: idle pattern and max_terms change between them
    phase_terms = '{7'd127, 7'd2, 7'($urandom_range(3, 126)), MAX_TERMS_RST};
    for (int ph = 0; ph < 4; ph++) begin
      write_terms(phase_terms[ph]);
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 18 : 0;
      for (int k = 0; k < RAND_PER_PHASE; k++) send_arg(rand_arg());
    end
    // with max_terms 0 the block still runs the first step
    write_terms(7'd0);
    for (int k = 0; k < 6; k++) send_arg(rand_arg());
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_exp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d results, %0d through the series, max_terms 0/2/100/127 and random,",
             results_seen, series_items);
    $display("with sender and receiver stalls in both proportions; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_exp_q.size() == 0)
      $display("exp_taylor_series_double test passed");
    else
      $display("exp_taylor_series_double test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/etsd_pkg.sv
hdl/exp_taylor_series_double.sv
tb/exp_taylor_series_double_tb.sv
